@@ sv/vpcm_pkg.sv @@
// vpcm_pkg: shared types and constants for the vertical point cluster merge unit
// no dependencies
`default_nettype none
package vpcm_pkg;
  localparam int unsigned MaxClustersDef = 16;
  localparam int unsigned CountBitsDef   = 16;
  localparam int unsigned CoordW         = 32;
  localparam int unsigned GapW           = 31;
  localparam int unsigned TolW           = 16;
  localparam int unsigned PigW           = 16;

  localparam logic RegXyTol  = 1'b0;
  localparam logic RegHgtGap = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DSTART,
    S_DWAIT,
    S_OUT,
    S_ADD
  } state_e;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic                     add;
    logic                     shift;
    logic signed [CoordW-1:0] z;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [GapW-1:0]          gap;
    logic [PigW-1:0]          pig;
  } cell_cmd_t;
endpackage
`default_nettype wire

@@ sv/vpcm_cell.sv @@
// vpcm_cell: one cluster slot of the chain, holds first height, sum, count and point xy
// depends on vpcm_pkg
`default_nettype none
module vpcm_cell #(
  parameter int unsigned CountBits = 16,
  parameter int unsigned Idx       = 0
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  vpcm_pkg::cell_cmd_t             cmd_i,
  input  wire                             taken_i,
  input  wire                             prev_valid_i,
  input  wire                             ovf_i,
  output logic                            taken_o,
  output logic                            ovf_o,
  output logic                            valid_o,
  input  wire                             nxt_valid_i,
  input  wire signed [31:0]               nxt_fz_i,
  input  wire signed [CountBits+31:0]     nxt_sum_i,
  input  wire [CountBits-1:0]             nxt_cnt_i,
  input  wire [63:0]                      nxt_xy_i,
  output logic signed [31:0]              fz_o,
  output logic signed [CountBits+31:0]    sum_o,
  output logic [CountBits-1:0]            cnt_o,
  output logic [63:0]                     xy_o
);
  import vpcm_pkg::*;
  localparam int unsigned SumW = CountBits + 32;
  localparam logic [CountBits-1:0] CntMax = '1;

  logic                     valid_q, valid_d;
  logic signed [31:0]       fz_q, fz_d;
  logic signed [SumW-1:0]   sum_q, sum_d;
  logic [CountBits-1:0]     cnt_q, cnt_d;
  logic [63:0]              xy_q, xy_d;
  logic signed [32:0]       diff;
  logic [32:0]              adiff;
  logic                     hit, join_here, open_here;

  assign diff      = {fz_q[31], fz_q} - {cmd_i.z[31], cmd_i.z};
  assign adiff     = diff[32] ? 33'(-diff) : 33'(diff);
  assign hit       = valid_q && (adiff < {2'b00, cmd_i.gap});
  assign join_here = cmd_i.add && hit && !taken_i;
  assign open_here = cmd_i.add && !valid_q && prev_valid_i && !taken_i;
  assign taken_o   = taken_i | hit;
  assign ovf_o     = ovf_i | (join_here && (cnt_q == CntMax));

  always_comb begin
    valid_d = valid_q;
    fz_d    = fz_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    xy_d    = xy_q;
    if (cmd_i.shift) begin
      valid_d = nxt_valid_i;
      fz_d    = nxt_fz_i;
      sum_d   = nxt_sum_i;
      cnt_d   = nxt_cnt_i;
      xy_d    = nxt_xy_i;
    end else if (cmd_i.add) begin
      if (cmd_i.pig == PigW'(Idx)) begin
        xy_d = {cmd_i.y, cmd_i.x};
      end
      if (open_here) begin
        valid_d = 1'b1;
        fz_d    = cmd_i.z;
        sum_d   = SumW'(cmd_i.z);
        cnt_d   = CountBits'(1);
      end else if (join_here && (cnt_q != CntMax)) begin
        sum_d = sum_q + SumW'(cmd_i.z);
        cnt_d = cnt_q + CountBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fz_q  <= fz_d;
    sum_q <= sum_d;
    cnt_q <= cnt_d;
    xy_q  <= xy_d;
  end

  assign valid_o = valid_q;
  assign fz_o    = fz_q;
  assign sum_o   = sum_q;
  assign cnt_o   = cnt_q;
  assign xy_o    = xy_q;
endmodule
`default_nettype wire

@@ sv/vpcm_div.sv @@
// vpcm_div: restoring divider, one quotient bit per cycle
// depends on vpcm_pkg
`default_nettype none
module vpcm_div #(
  parameter int unsigned CountBits = 16
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start_i,
  input  wire [CountBits+31:0]       dividend_i,
  input  wire [CountBits-1:0]        divisor_i,
  output logic                       done_o,
  output logic [CountBits+31:0]      quot_o
);
  import vpcm_pkg::*;
  localparam int unsigned SumW = CountBits + 32;
  localparam int unsigned CntW = $clog2(SumW + 1);

  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic [SumW-1:0]      quo_q, quo_d;
  logic [CountBits:0]   rem_q, rem_d, div_q, div_d;
  logic [CountBits:0]   trial;

  assign trial = {rem_q[CountBits-1:0], quo_q[SumW-1]};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(SumW);
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = {1'b0, divisor_i};
    end else if (busy_q) begin
      if (trial >= div_q) begin
        rem_d = trial - div_q;
        quo_d = {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[SumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule
`default_nettype wire

@@ sv/vertical_point_cluster_merge_unit.sv @@
// vertical point cluster merge unit: groups points by xy, clusters heights first-fit
// in a chain of cells and emits one rounded mean per cluster at group end
// depends on vpcm_pkg, vpcm_cell, vpcm_div
// a point kept in its group passes S_CHECK and S_ADD before ready returns in S_IDLE
// each group flush result passes S_DSTART, the serial divider in S_DWAIT, then S_OUT
// the chain shifts one cell towards cell 0 per result word taken
// reset clears control state and config to xy_tolerance 10, height_gap 1000
`default_nettype none
module vertical_point_cluster_merge_unit #(
  parameter int unsigned MaxClusters = vpcm_pkg::MaxClustersDef,
  parameter int unsigned CountBits   = vpcm_pkg::CountBitsDef
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [95:0]  s_axis_tdata,   // pos_x, pos_y, pos_z
  input  wire          s_axis_tlast,   // stream_end
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [95:0]  m_axis_tdata,   // out_x, out_y, out_z
  output logic         m_axis_tlast,   // group_last
  output logic [1:0]   m_axis_tuser,   // stream_last, table_overflow
  input  wire          cfg_we_i,
  input  wire          cfg_idx_i,
  input  wire  [30:0]  cfg_data_i
);
  import vpcm_pkg::*;
  localparam int unsigned SumW = CountBits + 32;
  localparam int unsigned CuW  = $clog2(MaxClusters + 1);

  state_e state_q, state_d;
  logic [TolW-1:0] tol_q;
  logic [GapW-1:0] gap_q;
  logic signed [31:0] x_q, y_q, z_q, gfx_q, gfy_q;
  logic end_q, open_q, ovf_q, add_pend_q, last_flush_q, sign_q;
  logic [CuW-1:0] used_q, rem_q;
  logic [PigW-1:0] pig_q;
  logic signed [32:0] dx, dy;
  logic [32:0] adx, ady;
  logic same_xy, div_start, div_done, opened, full;
  logic [SumW-1:0] div_num, quot, abs_sum;
  logic [31:0] mean;
  cell_cmd_t cmd;

  logic                  taken   [MaxClusters+1];
  logic                  pvalid  [MaxClusters+1];
  logic                  ovfc    [MaxClusters+1];
  logic                  cvalid  [MaxClusters+1];
  logic signed [31:0]    cfz     [MaxClusters+1];
  logic signed [SumW-1:0] csum   [MaxClusters+1];
  logic [CountBits-1:0]  ccnt    [MaxClusters+1];
  logic [63:0]           cxy     [MaxClusters+1];
  logic                  tk_out  [MaxClusters];
  logic                  ov_out  [MaxClusters];

  assign taken[0]  = 1'b0;
  assign pvalid[0] = 1'b1;
  assign ovfc[0]   = 1'b0;
  assign cvalid[MaxClusters] = 1'b0;
  assign cfz[MaxClusters]    = '0;
  assign csum[MaxClusters]   = '0;
  assign ccnt[MaxClusters]   = '0;
  assign cxy[MaxClusters]    = '0;

  genvar g;
  generate
    for (g = 0; g < MaxClusters; g++) begin : g_cell
      vpcm_cell #(.CountBits(CountBits), .Idx(g)) u_cell (
        .clk_i, .rst_ni, .cmd_i(cmd),
        .taken_i(taken[g]), .prev_valid_i(pvalid[g]), .ovf_i(ovfc[g]),
        .taken_o(tk_out[g]), .ovf_o(ov_out[g]), .valid_o(pvalid[g+1]),
        .nxt_valid_i(cvalid[g+1]), .nxt_fz_i(cfz[g+1]), .nxt_sum_i(csum[g+1]),
        .nxt_cnt_i(ccnt[g+1]), .nxt_xy_i(cxy[g+1]),
        .fz_o(cfz[g]), .sum_o(csum[g]), .cnt_o(ccnt[g]), .xy_o(cxy[g])
      );
      assign taken[g+1]  = tk_out[g];
      assign ovfc[g+1]   = ov_out[g];
      assign cvalid[g]   = pvalid[g+1];
    end
  endgenerate

  vpcm_div #(.CountBits(CountBits)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_num),
    .divisor_i(ccnt[0]), .done_o(div_done), .quot_o(quot)
  );

  assign dx      = {x_q[31], x_q} - {gfx_q[31], gfx_q};
  assign dy      = {y_q[31], y_q} - {gfy_q[31], gfy_q};
  assign adx     = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady     = dy[32] ? 33'(-dy) : 33'(dy);
  assign same_xy = (adx < {17'd0, tol_q}) && (ady < {17'd0, tol_q});

  // round half away from zero on the magnitude
  assign abs_sum   = csum[0][SumW-1] ? SumW'(-csum[0]) : SumW'(csum[0]);
  assign div_num   = abs_sum + SumW'(ccnt[0] >> 1);
  assign mean      = sign_q ? 32'(-quot) : quot[31:0];
  // a closed group leaves a stale cluster count behind
  assign full      = open_q && (used_q == CuW'(MaxClusters));
  assign opened    = !taken[MaxClusters] && !full;

  always_comb begin
    cmd.add   = (state_q == S_ADD);
    cmd.shift = (state_q == S_OUT) && m_axis_tready;
    cmd.z     = z_q;
    cmd.x     = x_q;
    cmd.y     = y_q;
    cmd.gap   = gap_q;
    cmd.pig   = open_q ? pig_q : '0;
  end

  assign div_start = (state_q == S_DSTART);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (s_axis_tvalid) state_d = S_CHECK;
      S_CHECK:  state_d = (open_q && !same_xy) ? S_DSTART : S_ADD;
      S_DSTART: state_d = S_DWAIT;
      S_DWAIT:  if (div_done) state_d = S_OUT;
      S_OUT: begin
        if (m_axis_tready) begin
          if (rem_q <= CuW'(1)) begin
            state_d = add_pend_q ? S_ADD : S_IDLE;
          end else begin
            state_d = S_DSTART;
          end
        end
      end
      S_ADD:    state_d = end_q ? S_DSTART : S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    m_axis_tvalid = (state_q == S_OUT);
    m_axis_tdata  = {mean, cxy[0]};
    m_axis_tlast  = (rem_q == CuW'(1));
    m_axis_tuser  = {ovf_q, last_flush_q && (rem_q == CuW'(1))};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      tol_q        <= TolW'(10);
      gap_q        <= GapW'(1000);
      open_q       <= 1'b0;
      gfx_q        <= '0;
      gfy_q        <= '0;
      used_q       <= '0;
      pig_q        <= '0;
      ovf_q        <= 1'b0;
      rem_q        <= '0;
      add_pend_q   <= 1'b0;
      last_flush_q <= 1'b0;
      end_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == RegXyTol) tol_q <= cfg_data_i[TolW-1:0];
        else                       gap_q <= cfg_data_i;
      end
      case (state_q)
        S_IDLE: if (s_axis_tvalid) end_q <= s_axis_tlast;
        S_CHECK: begin
          if (open_q && !same_xy) begin
            add_pend_q   <= 1'b1;
            last_flush_q <= 1'b0;
            rem_q        <= used_q;
          end
        end
        S_ADD: begin
          if (!open_q) begin
            gfx_q <= x_q;
            gfy_q <= y_q;
          end
          open_q <= !end_q;
          pig_q  <= (open_q ? ((pig_q == '1) ? pig_q : pig_q + PigW'(1)) : PigW'(1));
          used_q <= (open_q ? used_q : '0) + CuW'(opened);
          ovf_q  <= (open_q && ovf_q) || ovfc[MaxClusters] || (!taken[MaxClusters] && full);
          add_pend_q   <= 1'b0;
          last_flush_q <= 1'b1;
          rem_q        <= (open_q ? used_q : '0) + CuW'(opened);
        end
        S_OUT: begin
          if (m_axis_tready) begin
            rem_q <= rem_q - CuW'(1);
            if (rem_q <= CuW'(1)) open_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      x_q <= s_axis_tdata[31:0];
      y_q <= s_axis_tdata[63:32];
      z_q <= s_axis_tdata[95:64];
    end
    if (state_q == S_DSTART) sign_q <= csum[0][SumW-1];
  end
endmodule
`default_nettype wire
